// File: hdl/stp_pkg.sv
// ----------------------------------------------------------------------------
// Stepper step generator package
// Shared types, register indexes, command codes and the half-step table.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int unsigned ACTION_BITS   = 3;
  localparam int unsigned TARGET_BITS   = 32;
  localparam int unsigned COIL_BITS     = 4;
  localparam int unsigned PHASE_BITS    = 3;
  localparam int unsigned DIVIDE_BITS   = 8;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 8;

  localparam logic [DIVIDE_BITS-1:0] DIVIDE_RESET = 8'd60;

  // Command codes
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_TICK   = 3'd0,
    ACT_MOVE   = 3'd1,
    ACT_ORIGIN = 3'd2,
    ACT_PAUSE  = 3'd3,
    ACT_STOP   = 3'd4,
    ACT_START  = 3'd5
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DRIVER_MODE   = 2'd0,
    REG_PHASE_REVERSE = 2'd1,
    REG_TICK_DIVIDE   = 2'd2
  } cfg_reg_t;

  localparam logic MODE_FOUR_PHASE = 1'b0;
  localparam logic MODE_STEP_DIR   = 1'b1;

  typedef struct packed {
    logic                   driver_mode;
    logic                   phase_reverse;
    logic [DIVIDE_BITS-1:0] tick_divide;
  } cfg_t;

  typedef struct packed {
    logic [COIL_BITS-1:0]          coils;
    logic                          enable_n;
    logic                          dir_level;
    logic                          step_pulse;
    logic signed [TARGET_BITS-1:0] current_position;
    logic                          at_goal;
  } result_t;

  // Half-step coil pattern, bit0 A .. bit3 D
  function automatic logic [COIL_BITS-1:0] half_step_pattern(input logic [PHASE_BITS-1:0] ph);
    logic [COIL_BITS-1:0] pat;
    case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

// File: hdl/stp_cmd_if.sv
// ----------------------------------------------------------------------------
// Stepper command channel
// Valid/ready channel carrying one command request.
// ----------------------------------------------------------------------------
interface stp_cmd_if
  import stp_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic [ACTION_BITS-1:0]        action;
  logic signed [TARGET_BITS-1:0] target_position;

  modport source (output valid, output action, output target_position, input ready);
  modport sink   (input valid, input action, input target_position, output ready);
endinterface

// File: hdl/stp_res_if.sv
// ----------------------------------------------------------------------------
// Stepper result channel
// Valid/ready channel carrying one result request.
// ----------------------------------------------------------------------------
interface stp_res_if
  import stp_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic [COIL_BITS-1:0]          coils;
  logic                          enable_n;
  logic                          dir_level;
  logic                          step_pulse;
  logic signed [TARGET_BITS-1:0] current_position;
  logic                          at_goal;

  modport source (output valid, output coils, output enable_n, output dir_level,
                  output step_pulse, output current_position, output at_goal,
                  input ready);
  modport sink   (input valid, input coils, input enable_n, input dir_level,
                  input step_pulse, input current_position, input at_goal,
                  output ready);
endinterface

// File: hdl/stepper_position_step_generator.sv
// ----------------------------------------------------------------------------
// Stepper position step generator
// Half-step / step-direction controller: one command in, one result out.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake        Carries
//  -------  ---------  ---------------  ---------------------------------------
//  cmd      in         valid / ready    action, target_position
//  res      out        valid / ready    coils, enable_n, dir_level, step_pulse,
//                                       current_position, at_goal
//  cfg      in         cfg_write        cfg_index, cfg_data (no read-back)
//
//  One command per cycle while the result is not stalled; the result is set
//  by the command register and the result register with a single pass of
//  motion logic between them.
//  Reset (rst, synchronous) clears all motion state and loads the register
//  defaults; no clearing pass, a command can be taken the cycle after.
//  A stalled result holds; the command register keeps taking requests until
//  both stages are full.
//
module stepper_position_step_generator
  import stp_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  stp_cmd_if.sink                  cmd,
  stp_res_if.source                res,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t                          cfg;
  result_t                       result;
  result_t                       out_result;
  logic                          in_valid;
  logic [ACTION_BITS-1:0]        in_action;
  logic signed [TARGET_BITS-1:0] in_target;
  logic                          out_valid;
  logic                          advance;

  stp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the held request into the result stage whenever that stage is free
  // or being emptied this cycle; the motion state commits on the same edge.
  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  // Command register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_action <= cmd.action;
      in_target <= cmd.target_position;
    end
  end

  stp_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .advance         (advance),
    .action          (in_action),
    .target_position (in_target),
    .result          (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign res.valid            = out_valid;
  assign res.coils            = out_result.coils;
  assign res.enable_n         = out_result.enable_n;
  assign res.dir_level        = out_result.dir_level;
  assign res.step_pulse       = out_result.step_pulse;
  assign res.current_position = out_result.current_position;
  assign res.at_goal          = out_result.at_goal;

endmodule

// File: hdl/stp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Stepper configuration registers
// Decode the write port into driver mode, phase direction and tick divider.
// ----------------------------------------------------------------------------
module stp_cfg_regs
  import stp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.driver_mode   <= MODE_STEP_DIR;
      cfg.phase_reverse <= 1'b0;
      cfg.tick_divide   <= DIVIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DRIVER_MODE:   cfg.driver_mode   <= cfg_data[0];
        REG_PHASE_REVERSE: cfg.phase_reverse <= cfg_data[0];
        REG_TICK_DIVIDE:   cfg.tick_divide   <= cfg_data[DIVIDE_BITS-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// File: hdl/stp_core.sv
// ----------------------------------------------------------------------------
// Stepper motion core
// Hold position, goal and drive latches; work out one command per cycle while advance is high.
// ----------------------------------------------------------------------------
module stp_core
  import stp_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          advance,
  input  logic [ACTION_BITS-1:0]        action,
  input  logic signed [TARGET_BITS-1:0] target_position,
  output result_t                       result
);

  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] goal, goal_next;
  logic                     moving_up, moving_up_next;
  logic [DIVIDE_BITS-1:0]   tick_count, tick_count_next;
  logic [PHASE_BITS-1:0]    phase_index, phase_index_next;
  logic                     stopped, stopped_next;
  logic [COIL_BITS-1:0]     coil_latch, coil_latch_next;
  logic                     enable_latch, enable_latch_next;
  logic                     dir_latch, dir_latch_next;
  logic                     pulse;
  logic [DIVIDE_BITS-1:0]   count_inc;
  logic [POSITION_BITS-1:0] target_ext;
  logic                     fwd;
  logic signed [63:0]       position_wide;

  assign target_ext = POSITION_BITS'(target_position);
  assign count_inc  = tick_count + DIVIDE_BITS'(1);
  assign fwd        = cfg.phase_reverse ? moving_up : !moving_up;

  always_comb begin
    position_next     = position;
    goal_next         = goal;
    moving_up_next    = moving_up;
    tick_count_next   = tick_count;
    phase_index_next  = phase_index;
    stopped_next      = stopped;
    coil_latch_next   = coil_latch;
    enable_latch_next = enable_latch;
    dir_latch_next    = dir_latch;
    pulse             = 1'b0;
    case (action_t'(action))
      ACT_TICK: begin
        if (position != goal) begin
          if (count_inc >= cfg.tick_divide) begin
            tick_count_next = '0;
            position_next   = moving_up ? position + POSITION_BITS'(1)
                                        : position - POSITION_BITS'(1);
            if (cfg.driver_mode == MODE_FOUR_PHASE) begin
              coil_latch_next  = half_step_pattern(phase_index);
              phase_index_next = fwd ? phase_index + PHASE_BITS'(1)
                                     : phase_index - PHASE_BITS'(1);
            end else begin
              dir_latch_next = moving_up;
              pulse          = 1'b1;
            end
          end else begin
            tick_count_next = count_inc;
          end
        end
      end
      ACT_MOVE: begin
        goal_next = target_ext;
        if (position != target_ext) begin
          moving_up_next = $signed(target_ext) > $signed(position);
        end
      end
      ACT_ORIGIN: begin
        position_next = target_ext;
        goal_next     = target_ext;
      end
      ACT_PAUSE: begin
        goal_next = position;
      end
      ACT_STOP: begin
        if (!stopped) begin
          stopped_next = 1'b1;
          goal_next    = position;
          if (cfg.driver_mode == MODE_FOUR_PHASE) begin
            coil_latch_next = '0;
          end else begin
            enable_latch_next = 1'b1;
          end
        end
      end
      ACT_START: begin
        if (stopped) begin
          stopped_next = 1'b0;
          if (cfg.driver_mode == MODE_FOUR_PHASE) begin
            coil_latch_next = half_step_pattern(phase_index);
          end else begin
            enable_latch_next = 1'b0;
          end
        end
      end
      default: ;  // unused codes report the state unchanged
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      goal         <= '0;
      moving_up    <= 1'b0;
      tick_count   <= '0;
      phase_index  <= '0;
      stopped      <= 1'b0;
      coil_latch   <= '0;
      enable_latch <= 1'b0;
      dir_latch    <= 1'b0;
    end else if (advance) begin
      position     <= position_next;
      goal         <= goal_next;
      moving_up    <= moving_up_next;
      tick_count   <= tick_count_next;
      phase_index  <= phase_index_next;
      stopped      <= stopped_next;
      coil_latch   <= coil_latch_next;
      enable_latch <= enable_latch_next;
      dir_latch    <= dir_latch_next;
    end
  end

  assign position_wide = 64'($signed(position_next));

  always_comb begin
    result.coils            = coil_latch_next;
    result.enable_n         = enable_latch_next;
    result.dir_level        = dir_latch_next;
    result.step_pulse       = pulse;
    result.current_position = position_wide[TARGET_BITS-1:0];
    result.at_goal          = (position_next == goal_next);
  end

endmodule

// File: hdl/stp_checker.sv
// ----------------------------------------------------------------------------
// Stepper step generator checker
// Port-level checks on reset, stalls and request flow, bound to the top level.
// ----------------------------------------------------------------------------
module stp_checker
  import stp_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [COIL_BITS-1:0]          res_coils,
  input logic signed [TARGET_BITS-1:0] res_position,
  input logic                          res_at_goal
);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_coils)
      && $stable(res_position) && $stable(res_at_goal))
    else $error("stalled result changed");

  // The command side only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> res_valid && !res_ready)
    else $error("command stalled without output back-pressure");

  // An accepted request passes the command and result registers and reaches the output when not blocked
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) ##1 (!res_valid || res_ready) |=> res_valid)
    else $error("accepted request did not reach the output");

endmodule

bind stepper_position_step_generator stp_checker u_stp_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_coils    (res.coils),
  .res_position (res.current_position),
  .res_at_goal  (res.at_goal)
);

// File: sim/stepper_position_step_generator_test.sv
// ----------------------------------------------------------------------------
// Stepper position step generator regression
// Drives command requests into the step generator under random source and
// sink idling, predicts each result request from a behavioural motor model
// kept alongside the block, and checks every result field by field.
// ----------------------------------------------------------------------------
module stepper_position_step_generator_test;
  import stp_pkg::*;

  // Spare command codes: the block must ignore them and report its state
  localparam logic [ACTION_BITS-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_BITS-1:0] ACT_SPARE_7 = 3'd7;

  // Half-step coil sequence packed as nibbles, phase 0 in the low nibble
  localparam logic [31:0] HALF_STEP_COILS = 32'h98C4_6231;

  // Length of a receiver hold-off, long enough to fill both stages
  localparam int unsigned HOLD_CYCLES = 64;
  // Cycles to let pass after the last result before the verdict
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTED = 10;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  stp_cmd_if cmd_ch ();
  stp_res_if res_ch ();

  stepper_position_step_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Motor model: its own copy of the motion state and the register settings.
  // --------------------------------------------------------------------------
  logic [31:0]            motor_pos;
  logic [31:0]            motor_goal;
  logic                   heading_up;
  logic [DIVIDE_BITS-1:0] tick_tally;
  logic [PHASE_BITS-1:0]  phase_idx;
  logic                   parked;
  logic [COIL_BITS-1:0]   coil_hold;
  logic                   enable_hold;
  logic                   dir_hold;

  logic                   set_mode;
  logic                   set_reverse;
  logic [DIVIDE_BITS-1:0] set_divide;

  // Results owed by the block, oldest first
  result_t motor_reports [$];

  int unsigned mismatch_count = 0;

  // Idling odds in percent, changed per test
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;

  // Hold-off requests: the test bumps hold_asks, the sink process counts
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  function automatic void reset_motor_model();
    motor_pos   = '0;
    motor_goal  = '0;
    heading_up  = 1'b0;
    tick_tally  = '0;
    phase_idx   = '0;
    parked      = 1'b0;
    coil_hold   = '0;
    enable_hold = 1'b0;
    dir_hold    = 1'b0;
    set_mode    = MODE_STEP_DIR;
    set_reverse = 1'b0;
    set_divide  = DIVIDE_RESET;
  endfunction

  // Apply one command to the model and return the result it owes.
  function automatic result_t predict_motor_report(logic [ACTION_BITS-1:0] act,
                                                   logic [31:0] tgt);
    result_t rep;
    logic    pulse;
    logic    forward;
    pulse = 1'b0;
    case (act)
      ACT_TICK: begin
        // A tick only counts while there is somewhere to go
        if (motor_pos != motor_goal) begin
          tick_tally = tick_tally + 1'b1;
          // A divide of zero falls through here on every tick, as a divide of one
          if (tick_tally >= set_divide) begin
            tick_tally = '0;
            motor_pos  = heading_up ? motor_pos + 32'd1 : motor_pos - 32'd1;
            if (set_mode == MODE_FOUR_PHASE) begin
              forward   = set_reverse ? heading_up : !heading_up;
              coil_hold = HALF_STEP_COILS[phase_idx*4 +: 4];
              phase_idx = forward ? phase_idx + 1'b1 : phase_idx - 1'b1;
            end else begin
              dir_hold = heading_up;
              pulse    = 1'b1;
            end
          end
        end
      end
      ACT_MOVE: begin
        motor_goal = tgt;
        // A move to where the motor already is keeps the old heading
        if (motor_pos != motor_goal) heading_up = $signed(motor_goal) > $signed(motor_pos);
      end
      ACT_ORIGIN: begin
        motor_pos  = tgt;
        motor_goal = tgt;
      end
      ACT_PAUSE: motor_goal = motor_pos;
      ACT_STOP: begin
        if (!parked) begin
          parked     = 1'b1;
          motor_goal = motor_pos;
          if (set_mode == MODE_FOUR_PHASE) coil_hold = '0;
          else enable_hold = 1'b1;
        end
      end
      ACT_START: begin
        if (parked) begin
          parked = 1'b0;
          if (set_mode == MODE_FOUR_PHASE) coil_hold = HALF_STEP_COILS[phase_idx*4 +: 4];
          else enable_hold = 1'b0;
        end
      end
      default: ;
    endcase
    rep.coils            = coil_hold;
    rep.enable_n         = enable_hold;
    rep.dir_level        = dir_hold;
    rep.step_pulse       = pulse;
    rep.current_position = motor_pos;
    rep.at_goal          = (motor_pos == motor_goal);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: random ready, overridden by a counted hold-off when asked.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen    <= hold_asks;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest owed one.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t owed;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (motor_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("unexpected result: position %h", res_ch.current_position);
      end else begin
        owed = motor_reports.pop_front();
        check_field("coils", owed.coils, res_ch.coils);
        check_field("enable_n", owed.enable_n, res_ch.enable_n);
        check_field("dir_level", owed.dir_level, res_ch.dir_level);
        check_field("step_pulse", owed.step_pulse, res_ch.step_pulse);
        check_field("current_position", owed.current_position, res_ch.current_position);
        check_field("at_goal", owed.at_goal, res_ch.at_goal);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command source
  // --------------------------------------------------------------------------

  // Offer one command request, idling first at random, and predict its
  // result once the block has taken it.
  task automatic send_command(logic [ACTION_BITS-1:0] act, logic [31:0] tgt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.action          <= act;
    cmd_ch.target_position <= tgt;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    motor_reports.push_back(predict_motor_report(act, tgt));
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (motor_reports.size() != 0) @(posedge clk);
  endtask

  // Write all three registers once the block is idle.
  task automatic load_settings(logic mode, logic rev, logic [DIVIDE_BITS-1:0] div);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_DRIVER_MODE;
    cfg_data  <= {{(CFG_DATA_BITS-1){1'b0}}, mode};
    @(posedge clk);
    set_mode  = mode;
    cfg_index <= REG_PHASE_REVERSE;
    cfg_data  <= {{(CFG_DATA_BITS-1){1'b0}}, rev};
    @(posedge clk);
    set_reverse = rev;
    cfg_index <= REG_TICK_DIVIDE;
    cfg_data  <= div;
    @(posedge clk);
    set_divide = div;
    cfg_write <= 1'b0;
  endtask

  // Random command mix: mostly ticks behind short moves near the current
  // position, so the motor keeps reaching and leaving its goal; the rest is
  // far moves, origins near the signed limits, pauses, stop/start and noise.
  task automatic run_command_mix(int unsigned count, int unsigned tick_pct);
    int unsigned roll;
    logic [31:0] noise;
    logic [31:0] offset;
    repeat (count) begin
      roll   = $urandom_range(0, 99);
      noise  = $urandom();
      offset = $urandom_range(0, 16);
      if (roll < tick_pct) begin
        send_command(ACT_TICK, noise);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 45) send_command(ACT_MOVE, motor_pos + offset - 32'd8);
        else if (roll < 55) send_command(ACT_MOVE, noise);
        else if (roll < 63) send_command(ACT_ORIGIN, noise);
        else if (roll < 68)
          send_command(ACT_ORIGIN, noise[0] ? 32'h7FFF_FFF0 + offset : 32'h8000_0000 + offset);
        else if (roll < 76) send_command(ACT_PAUSE, noise);
        else if (roll < 85) send_command(ACT_STOP, noise);
        else if (roll < 94) send_command(ACT_START, noise);
        else if (roll < 97) send_command(ACT_SPARE_6, noise);
        else send_command(ACT_SPARE_7, noise);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked commands: every code, the signed extremes, and the corner
  // cases of stop/start, zero divide, stale heading and the tick count.
  task automatic test_directed_commands();
    send_idle_pct = 0;
    take_idle_pct = 0;
    // Reset settings: step/dir drive, divide of sixty
    send_command(ACT_TICK, 32'hFFFF_FFFF);    // at goal, nothing happens
    send_command(ACT_SPARE_6, 32'h0000_0000);
    send_command(ACT_SPARE_7, 32'hFFFF_FFFF);
    send_command(ACT_STOP, 32'h0);            // raise enable_n
    send_command(ACT_STOP, 32'h0);            // already stopped
    send_command(ACT_START, 32'h0);
    send_command(ACT_START, 32'h0);           // already running
    send_command(ACT_MOVE, 32'h0);            // move to the current position
    send_command(ACT_ORIGIN, 32'h7FFF_FFFF);
    send_command(ACT_MOVE, 32'h8000_0000);
    send_command(ACT_PAUSE, 32'h5555_5555);
    send_command(ACT_ORIGIN, 32'h8000_0000);
    // Four-phase drive, phase follows motion, zero divide steps every tick
    load_settings(MODE_FOUR_PHASE, 1'b1, 8'd0);
    send_command(ACT_MOVE, 32'h8000_0003);
    send_command(ACT_TICK, 32'hAAAA_AAAA);
    send_command(ACT_TICK, 32'h5555_5555);
    send_command(ACT_STOP, 32'h0);            // coils off, goal parked
    send_command(ACT_MOVE, 32'h8000_0000);    // a move still steps while stopped
    send_command(ACT_TICK, 32'h0);
    send_command(ACT_START, 32'h0);           // coils back on
    send_command(ACT_ORIGIN, 32'h0);
    // Inverted phase order; the tick count must survive a new move
    load_settings(MODE_FOUR_PHASE, 1'b0, 8'd3);
    send_command(ACT_MOVE, 32'hFFFF_FFFE);
    send_command(ACT_TICK, 32'h0);
    send_command(ACT_TICK, 32'h0);
    send_command(ACT_MOVE, 32'h0000_0002);
    send_command(ACT_TICK, 32'h0);
  endtask

  task automatic test_step_dir_drive();
    load_settings(MODE_STEP_DIR, 1'b0, 8'd1);
    send_idle_pct = 15;
    take_idle_pct = 54;
    run_command_mix(250, 68);
  endtask

  task automatic test_four_phase_drive();
    load_settings(MODE_FOUR_PHASE, 1'b1, 8'd2);
    send_idle_pct = 54;
    take_idle_pct = 15;
    run_command_mix(250, 68);
  endtask

  task automatic test_inverted_phase_order();
    load_settings(MODE_FOUR_PHASE, 1'b0, 8'd3);
    send_idle_pct = 0;
    take_idle_pct = 0;
    run_command_mix(250, 68);
  endtask

  // Largest divide: nearly all ticks so that a step still comes through
  task automatic test_slowest_divide();
    load_settings(MODE_STEP_DIR, 1'b1, 8'd255);
    run_command_mix(300, 92);
  endtask

  // Long receiver hold-offs while the source keeps offering, so the block
  // fills both stages and must stall its command input.
  task automatic test_result_back_pressure();
    load_settings(MODE_FOUR_PHASE, 1'b1, 8'd0);
    hold_asks++;
    run_command_mix(100, 68);
    hold_asks++;
    run_command_mix(100, 68);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = REG_DRIVER_MODE;
    cfg_data               = '0;
    cmd_ch.valid           = 1'b0;
    cmd_ch.action          = ACT_TICK;
    cmd_ch.target_position = '0;
    res_ch.ready           = 1'b0;
    reset_motor_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_commands();
    test_step_dir_drive();
    test_four_phase_drive();
    test_inverted_phase_order();
    test_slowest_divide();
    test_result_back_pressure();

    // Let the last results through, then wait out the settling time for stragglers
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && motor_reports.size() == 0) begin
      $display("stepper_position_step_generator regression: pass");
    end else begin
      $display("stepper_position_step_generator regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #400000;
    $display("stepper_position_step_generator regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
hdl/stp_pkg.sv
hdl/stp_cmd_if.sv
hdl/stp_res_if.sv
hdl/stp_cfg_regs.sv
hdl/stp_core.sv
hdl/stepper_position_step_generator.sv
hdl/stp_checker.sv
sim/stepper_position_step_generator_test.sv
